FILE: hw/rtl/q931_call_state_machine_defines.svh
// Assertion macros shared by the call state machine checkers.
`ifndef Q931_CALL_STATE_MACHINE_DEFINES_SVH
`define Q931_CALL_STATE_MACHINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define Q931_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define Q931_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/q931_pkg.sv
// Package: call state, event and action codes, transition table and shared types.
package q931_pkg;

    localparam int unsigned STATE_W  = 4;
    localparam int unsigned EVENT_W  = 4;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned NUM_TMO  = 6;
    localparam int unsigned TMO_IDX_W = $clog2(NUM_TMO);
    localparam int unsigned NUM_TRANS = 28;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // Call states
    localparam logic [STATE_W-1:0] ST_NULL        = 4'd0;
    localparam logic [STATE_W-1:0] ST_OUT_SETUP   = 4'd1;
    localparam logic [STATE_W-1:0] ST_OVERLAP     = 4'd2;
    localparam logic [STATE_W-1:0] ST_OUT_PROC    = 4'd3;
    localparam logic [STATE_W-1:0] ST_IN_OFFER    = 4'd4;
    localparam logic [STATE_W-1:0] ST_IN_PROC     = 4'd5;
    localparam logic [STATE_W-1:0] ST_CONN_PEND   = 4'd6;
    localparam logic [STATE_W-1:0] ST_CONNECTED   = 4'd7;
    localparam logic [STATE_W-1:0] ST_DISC_PEND   = 4'd8;
    localparam logic [STATE_W-1:0] ST_SEL_PROT    = 4'd9;
    localparam logic [STATE_W-1:0] ST_ACT_PROT    = 4'd10;

    // Events
    localparam logic [EVENT_W-1:0] EV_SETUP_REQ   = 4'd0;
    localparam logic [EVENT_W-1:0] EV_SETUP_RESP  = 4'd1;
    localparam logic [EVENT_W-1:0] EV_PROCEED_REQ = 4'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASE_REQ = 4'd3;
    localparam logic [EVENT_W-1:0] EV_INC_SETUP   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_CALL_PROC   = 4'd5;
    localparam logic [EVENT_W-1:0] EV_SETUP_ACK   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_CONNECT     = 4'd7;
    localparam logic [EVENT_W-1:0] EV_CONNECT_ACK = 4'd8;
    localparam logic [EVENT_W-1:0] EV_DISCONNECT  = 4'd9;
    localparam logic [EVENT_W-1:0] EV_RELEASE     = 4'd10;
    localparam logic [EVENT_W-1:0] EV_REL_COMPL   = 4'd11;
    localparam logic [EVENT_W-1:0] EV_SELECT_ACK  = 4'd12;
    localparam logic [EVENT_W-1:0] EV_ACTIVATE_ACK = 4'd13;
    localparam logic [EVENT_W-1:0] EV_EXPIRY      = 4'd14;
    localparam logic [EVENT_W-1:0] EV_NONE        = 4'd15;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_NONE    = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_OUT1    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_NOTDONE = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_OUT2    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_DISC1   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_DISC2   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_IN1     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_IN2     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_IN3     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_DISC3   = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_SELP1   = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_OPEN    = 4'd11;

    // Timeout register indexes
    localparam logic [TMO_IDX_W-1:0] TMO_CALL_PROC = 3'd0;
    localparam logic [TMO_IDX_W-1:0] TMO_DISC_REQ  = 3'd1;
    localparam logic [TMO_IDX_W-1:0] TMO_SEL_PROT  = 3'd2;
    localparam logic [TMO_IDX_W-1:0] TMO_ACT_PROT  = 3'd3;
    localparam logic [TMO_IDX_W-1:0] TMO_IN_PROC   = 3'd4;
    localparam logic [TMO_IDX_W-1:0] TMO_CONN_REQ  = 3'd5;

    typedef logic [COUNT_W-1:0] t_tmo_arr [NUM_TMO];

    localparam logic [COUNT_W-1:0] TMO_RESET [NUM_TMO] = '{
        8'd10, 8'd2, 8'd5, 8'd5, 8'd10, 8'd2
    };

    typedef struct packed {
        logic [STATE_W-1:0]  from_st;
        logic [STATE_W-1:0]  to_st;
        logic [EVENT_W-1:0]  ev;
        logic [ACTION_W-1:0] act;
    } t_trans;

    localparam t_trans TRANS_TAB [NUM_TRANS] = '{
        '{ST_NULL,      ST_OUT_SETUP, EV_SETUP_REQ,    ACT_OUT1},
        '{ST_OUT_SETUP, ST_OVERLAP,   EV_SETUP_ACK,    ACT_NOTDONE},
        '{ST_OUT_SETUP, ST_OUT_PROC,  EV_CALL_PROC,    ACT_NONE},
        '{ST_OUT_SETUP, ST_NULL,      EV_DISCONNECT,   ACT_OUT2},
        '{ST_OUT_PROC,  ST_SEL_PROT,  EV_CONNECT,      ACT_OUT2},
        '{ST_OUT_PROC,  ST_NULL,      EV_DISCONNECT,   ACT_DISC1},
        '{ST_OUT_PROC,  ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_NULL,      ST_IN_OFFER,  EV_INC_SETUP,    ACT_NONE},
        '{ST_IN_OFFER,  ST_IN_PROC,   EV_PROCEED_REQ,  ACT_IN1},
        '{ST_IN_OFFER,  ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_IN_PROC,   ST_CONN_PEND, EV_SETUP_RESP,   ACT_IN2},
        '{ST_IN_PROC,   ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_CONN_PEND, ST_SEL_PROT,  EV_CONNECT_ACK,  ACT_IN3},
        '{ST_CONNECTED, ST_NULL,      EV_DISCONNECT,   ACT_DISC1},
        '{ST_CONNECTED, ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_CONNECTED, ST_NULL,      EV_RELEASE,      ACT_DISC3},
        '{ST_DISC_PEND, ST_NULL,      EV_DISCONNECT,   ACT_DISC1},
        '{ST_DISC_PEND, ST_NULL,      EV_RELEASE,      ACT_DISC3},
        '{ST_SEL_PROT,  ST_ACT_PROT,  EV_SELECT_ACK,   ACT_SELP1},
        '{ST_SEL_PROT,  ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_ACT_PROT,  ST_CONNECTED, EV_ACTIVATE_ACK, ACT_OPEN},
        '{ST_ACT_PROT,  ST_DISC_PEND, EV_RELEASE_REQ,  ACT_DISC2},
        '{ST_OUT_PROC,  ST_DISC_PEND, EV_EXPIRY,       ACT_DISC2},
        '{ST_DISC_PEND, ST_NULL,      EV_EXPIRY,       ACT_DISC3},
        '{ST_SEL_PROT,  ST_DISC_PEND, EV_EXPIRY,       ACT_DISC2},
        '{ST_ACT_PROT,  ST_DISC_PEND, EV_EXPIRY,       ACT_DISC2},
        '{ST_IN_PROC,   ST_DISC_PEND, EV_EXPIRY,       ACT_DISC2},
        '{ST_CONN_PEND, ST_CONN_PEND, EV_EXPIRY,       ACT_IN2}
    };

    // Outcome of one item: result word and next call/timer state.
    typedef struct packed {
        logic                res_valid;
        logic                from_timeout;
        logic                accepted;
        logic [ACTION_W-1:0] action;
        logic [STATE_W-1:0]  nxt_state;
        logic [COUNT_W-1:0]  nxt_count;
        logic                nxt_running;
    } t_step;

endpackage

FILE: hw/rtl/q931_step.sv
// Combinational next-state logic for one item: lookup, timer reload and countdown.
module q931_step (
    input  logic                            i_func,
    input  logic [q931_pkg::EVENT_W-1:0]    i_event_code,
    input  logic [q931_pkg::STATE_W-1:0]    i_state,
    input  logic [q931_pkg::COUNT_W-1:0]    i_count,
    input  logic                            i_running,
    input  q931_pkg::t_tmo_arr              i_tmo,
    output q931_pkg::t_step                 o_step
);
    import q931_pkg::*;

    logic [EVENT_W-1:0]   ev;
    logic                 expire;
    logic                 hit;
    logic [STATE_W-1:0]   hit_to;
    logic [ACTION_W-1:0]  hit_act;
    logic                 to_timed;
    logic [TMO_IDX_W-1:0] to_idx;

    // Ticks map to the expiry event; meaningless codes match nothing.
    always_comb begin
        if (i_func) begin
            ev = EV_EXPIRY;
        end else if (i_event_code <= EV_ACTIVATE_ACK) begin
            ev = i_event_code;
        end else begin
            ev = EV_NONE;
        end
    end

    assign expire = i_func && i_running && (i_count <= COUNT_W'(1));

    // Keys are unique; scan high to low so the first entry wins anyway.
    always_comb begin
        hit     = 1'b0;
        hit_to  = i_state;
        hit_act = ACT_NONE;
        for (int k = NUM_TRANS - 1; k >= 0; k--) begin
            if (TRANS_TAB[k].from_st == i_state && TRANS_TAB[k].ev == ev) begin
                hit     = 1'b1;
                hit_to  = TRANS_TAB[k].to_st;
                hit_act = TRANS_TAB[k].act;
            end
        end
    end

    always_comb begin
        to_timed = 1'b1;
        to_idx   = TMO_CALL_PROC;
        case (hit_to)
            ST_OUT_PROC:  to_idx = TMO_CALL_PROC;
            ST_DISC_PEND: to_idx = TMO_DISC_REQ;
            ST_SEL_PROT:  to_idx = TMO_SEL_PROT;
            ST_ACT_PROT:  to_idx = TMO_ACT_PROT;
            ST_IN_PROC:   to_idx = TMO_IN_PROC;
            ST_CONN_PEND: to_idx = TMO_CONN_REQ;
            default:      to_timed = 1'b0;
        endcase
    end

    always_comb begin
        o_step              = '0;
        o_step.from_timeout = i_func;
        o_step.nxt_state    = i_state;
        o_step.nxt_count    = i_count;
        o_step.nxt_running  = i_running;
        if (i_func && !expire) begin
            // Plain countdown, or idle tick: no result.
            if (i_running) begin
                o_step.nxt_count = i_count - COUNT_W'(1);
            end
        end else begin
            o_step.res_valid = 1'b1;
            if (expire) begin
                o_step.nxt_count   = '0;
                o_step.nxt_running = 1'b0;
            end
            if (hit) begin
                o_step.accepted    = 1'b1;
                o_step.action      = hit_act;
                o_step.nxt_state   = hit_to;
                o_step.nxt_running = to_timed;
                o_step.nxt_count   = to_timed ? i_tmo[to_idx] : '0;
            end
        end
    end

endmodule

FILE: hw/rtl/q931_call_state_machine.sv
// Top level: Q.931 call-control state machine with one-second state timer.
//
// Input channel (i_in_valid / o_in_stall) carries one word per item: i_func
// selects a call event (0) or a one-second tick (1); i_event_code is the event.
// Output channel (o_out_valid / i_out_stall) carries one result word per call
// event and per timer expiry; plain countdown ticks and ticks with the timer
// stopped give no word.
// A taken word sits in the input register, is evaluated from there and its
// result is loaded into the result register.
// Throughput: one item per cycle while the output is not stalled; the transition
// lookup and timer decrement both fit between the input and result registers,
// so the item after this one already sees the updated state.
// A stall on the output holds the result word; the input register then holds
// its word too and o_in_stall rises, so nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) returns to the null state with the timer
// stopped, loads the default timeouts and empties both registers.
// Six 8-bit timeout registers sit on the APB port at byte addresses 0..20,
// in steps of 4; a new timeout only takes effect at the next reload.
module q931_call_state_machine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item in
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [q931_pkg::EVENT_W-1:0]       i_event_code,
    // result out
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_from_timeout,
    output logic                               o_accepted,
    output logic [q931_pkg::STATE_W-1:0]       o_old_state,
    output logic [q931_pkg::STATE_W-1:0]       o_new_state,
    output logic [q931_pkg::ACTION_W-1:0]      o_action_code,
    output logic                               o_timer_armed,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [q931_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [q931_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [q931_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import q931_pkg::*;

    // Timeout registers
    logic [COUNT_W-1:0]   r_tmo [NUM_TMO];
    logic [TMO_IDX_W-1:0] cfg_idx;
    logic                 cfg_in_range;
    logic                 cfg_wr;

    // Input register
    logic                 r_in_valid;
    logic                 r_func;
    logic [EVENT_W-1:0]   r_event_code;

    // Call and timer state
    logic [STATE_W-1:0]   r_state;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_running;

    // Result register
    logic                 r_out_valid;
    logic                 r_from_timeout;
    logic                 r_accepted;
    logic [STATE_W-1:0]   r_old_state;
    logic [STATE_W-1:0]   r_new_state;
    logic [ACTION_W-1:0]  r_action;
    logic                 r_armed;

    t_step                step;
    logic                 fire;
    logic                 in_take;

    // ---------------------------------------------------------------- APB
    assign pready       = 1'b1;
    assign cfg_idx      = paddr[TMO_IDX_W+1:2];
    assign cfg_in_range = (cfg_idx < TMO_IDX_W'(NUM_TMO));
    assign cfg_wr       = psel && penable && pwrite && cfg_in_range;

    always_comb begin
        prdata = '0;
        if (cfg_in_range) begin
            prdata = APB_DATA_W'(r_tmo[cfg_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo <= TMO_RESET;
        end else if (cfg_wr) begin
            r_tmo[cfg_idx] <= pwdata[COUNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- step
    q931_step u_step (
        .i_func       (r_func),
        .i_event_code (r_event_code),
        .i_state      (r_state),
        .i_count      (r_count),
        .i_running    (r_running),
        .i_tmo        (r_tmo),
        .o_step       (step)
    );

    // Evaluate the held word once the result slot is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: load on accept, drop once evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func       <= i_func;
            r_event_code <= i_event_code;
        end
    end

    // Advance call state and timer on every evaluated word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_NULL;
            r_count   <= '0;
            r_running <= 1'b0;
        end else if (fire) begin
            r_state   <= step.nxt_state;
            r_count   <= step.nxt_count;
            r_running <= step.nxt_running;
        end
    end

    // Result register: hold under stall, clear when taken with nothing new.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step.res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step.res_valid) begin
            r_from_timeout <= step.from_timeout;
            r_accepted     <= step.accepted;
            r_old_state    <= r_state;
            r_new_state    <= step.nxt_state;
            r_action       <= step.action;
            r_armed        <= step.nxt_running;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_from_timeout = r_from_timeout;
    assign o_accepted     = r_accepted;
    assign o_old_state    = r_old_state;
    assign o_new_state    = r_new_state;
    assign o_action_code  = r_action;
    assign o_timer_armed  = r_armed;

endmodule

FILE: hw/rtl/q931_call_state_machine_chk.sv
// Port-level checker for the call state machine, bound to the top level.
`include "q931_call_state_machine_defines.svh"

module q931_call_state_machine_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_from_timeout,
    input  logic                            o_accepted,
    input  logic [q931_pkg::STATE_W-1:0]    o_old_state,
    input  logic [q931_pkg::STATE_W-1:0]    o_new_state,
    input  logic [q931_pkg::ACTION_W-1:0]   o_action_code,
    input  logic                            o_timer_armed
);
    import q931_pkg::*;

    logic new_timed;
    logic old_timed;

    assign new_timed = (o_new_state == ST_OUT_PROC) || (o_new_state == ST_IN_PROC) ||
                       (o_new_state == ST_CONN_PEND) || (o_new_state == ST_DISC_PEND) ||
                       (o_new_state == ST_SEL_PROT) || (o_new_state == ST_ACT_PROT);
    assign old_timed = (o_old_state == ST_OUT_PROC) || (o_old_state == ST_IN_PROC) ||
                       (o_old_state == ST_CONN_PEND) || (o_old_state == ST_DISC_PEND) ||
                       (o_old_state == ST_SEL_PROT) || (o_old_state == ST_ACT_PROT);

    // A rejected event leaves the state alone and runs nothing.
    `Q931_ASSERT_NOW(a_reject_noop, i_clk, i_rst_n,
        o_out_valid && !o_accepted && !o_from_timeout,
        (o_new_state == o_old_state) && (o_action_code == ACT_NONE),
        "rejected event changed state or ran an action")

    // After a taken transition the timer runs exactly in timed states.
    `Q931_ASSERT_NOW(a_arm_timed, i_clk, i_rst_n,
        o_out_valid && o_accepted,
        o_timer_armed == new_timed,
        "timer arming does not match the new state")

    // Expiry can only come out of a state that has a timeout.
    `Q931_ASSERT_NOW(a_expiry_src, i_clk, i_rst_n,
        o_out_valid && o_from_timeout,
        old_timed,
        "timer expiry reported from an untimed state")

    // A stalled result word stays put.
    `Q931_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_new_state) && $stable(o_action_code),
        "stalled result word changed")

endmodule

bind q931_call_state_machine q931_call_state_machine_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_from_timeout (o_from_timeout),
    .o_accepted     (o_accepted),
    .o_old_state    (o_old_state),
    .o_new_state    (o_new_state),
    .o_action_code  (o_action_code),
    .o_timer_armed  (o_timer_armed)
);

FILE: dv/q931_call_sb_pkg.sv
// Scoreboard for the call state machine: state and timer prediction plus result checks.
`timescale 1ns / 1ps

package q931_call_sb_pkg;

    import q931_pkg::*;

    localparam bit FN_EVENT = 1'b0;
    localparam bit FN_TICK  = 1'b1;

    typedef struct packed {
        logic                from_timeout;
        logic                accepted;
        logic [STATE_W-1:0]  old_state;
        logic [STATE_W-1:0]  new_state;
        logic [ACTION_W-1:0] action;
        logic                armed;
    } t_call_result;

    class call_scoreboard;

        logic [STATE_W-1:0] call_st;
        logic [COUNT_W-1:0] tmr_count;
        bit                 tmr_run;
        logic [COUNT_W-1:0] tmo_regs [NUM_TMO];
        t_call_result       expected_q [$];
        int                 errors;

        function new();
            call_st   = ST_NULL;
            tmr_count = '0;
            tmr_run   = 1'b0;
            errors    = 0;
            // call proc, disconnect req, select, activate, incoming proc, connect req
            tmo_regs  = '{8'd10, 8'd2, 8'd5, 8'd5, 8'd10, 8'd2};
        endfunction

        function void set_timeout(int idx, logic [COUNT_W-1:0] val);
            if (idx < NUM_TMO)
                tmo_regs[idx] = val;
        endfunction

        // {hit, next state, action}
        function logic [8:0] find_transition(logic [STATE_W-1:0] st, logic [EVENT_W-1:0] ev);
            logic [8:0] hit;
            hit = '0;
            case ({st, ev})
                {ST_NULL,      EV_SETUP_REQ}:    hit = {1'b1, ST_OUT_SETUP, ACT_OUT1};
                {ST_OUT_SETUP, EV_SETUP_ACK}:    hit = {1'b1, ST_OVERLAP,   ACT_NOTDONE};
                {ST_OUT_SETUP, EV_CALL_PROC}:    hit = {1'b1, ST_OUT_PROC,  ACT_NONE};
                {ST_OUT_SETUP, EV_DISCONNECT}:   hit = {1'b1, ST_NULL,      ACT_OUT2};
                {ST_OUT_PROC,  EV_CONNECT}:      hit = {1'b1, ST_SEL_PROT,  ACT_OUT2};
                {ST_OUT_PROC,  EV_DISCONNECT}:   hit = {1'b1, ST_NULL,      ACT_DISC1};
                {ST_OUT_PROC,  EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_NULL,      EV_INC_SETUP}:    hit = {1'b1, ST_IN_OFFER,  ACT_NONE};
                {ST_IN_OFFER,  EV_PROCEED_REQ}:  hit = {1'b1, ST_IN_PROC,   ACT_IN1};
                {ST_IN_OFFER,  EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_IN_PROC,   EV_SETUP_RESP}:   hit = {1'b1, ST_CONN_PEND, ACT_IN2};
                {ST_IN_PROC,   EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_CONN_PEND, EV_CONNECT_ACK}:  hit = {1'b1, ST_SEL_PROT,  ACT_IN3};
                {ST_CONNECTED, EV_DISCONNECT}:   hit = {1'b1, ST_NULL,      ACT_DISC1};
                {ST_CONNECTED, EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_CONNECTED, EV_RELEASE}:      hit = {1'b1, ST_NULL,      ACT_DISC3};
                {ST_DISC_PEND, EV_DISCONNECT}:   hit = {1'b1, ST_NULL,      ACT_DISC1};
                {ST_DISC_PEND, EV_RELEASE}:      hit = {1'b1, ST_NULL,      ACT_DISC3};
                {ST_SEL_PROT,  EV_SELECT_ACK}:   hit = {1'b1, ST_ACT_PROT,  ACT_SELP1};
                {ST_SEL_PROT,  EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_ACT_PROT,  EV_ACTIVATE_ACK}: hit = {1'b1, ST_CONNECTED, ACT_OPEN};
                {ST_ACT_PROT,  EV_RELEASE_REQ}:  hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_OUT_PROC,  EV_EXPIRY}:       hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_DISC_PEND, EV_EXPIRY}:       hit = {1'b1, ST_NULL,      ACT_DISC3};
                {ST_SEL_PROT,  EV_EXPIRY}:       hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_ACT_PROT,  EV_EXPIRY}:       hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_IN_PROC,   EV_EXPIRY}:       hit = {1'b1, ST_DISC_PEND, ACT_DISC2};
                {ST_CONN_PEND, EV_EXPIRY}:       hit = {1'b1, ST_CONN_PEND, ACT_IN2};
                default:                         hit = '0;
            endcase
            return hit;
        endfunction

        function int timeout_index(logic [STATE_W-1:0] st);
            case (st)
                ST_OUT_PROC:  return TMO_CALL_PROC;
                ST_DISC_PEND: return TMO_DISC_REQ;
                ST_SEL_PROT:  return TMO_SEL_PROT;
                ST_ACT_PROT:  return TMO_ACT_PROT;
                ST_IN_PROC:   return TMO_IN_PROC;
                ST_CONN_PEND: return TMO_CONN_REQ;
                default:      return -1;
            endcase
        endfunction

        function void take_event(logic [EVENT_W-1:0] ev, bit from_tmr);
            logic [8:0]   hit;
            t_call_result res;
            int           k;
            res.from_timeout = from_tmr;
            res.old_state    = call_st;
            hit = find_transition(call_st, ev);
            if (hit[8]) begin
                call_st   = hit[7:4];
                tmr_run   = 1'b0;
                tmr_count = '0;
                k = timeout_index(call_st);
                if (k >= 0) begin
                    tmr_run   = 1'b1;
                    tmr_count = tmo_regs[k];
                end
                res.accepted = 1'b1;
                res.action   = hit[3:0];
            end else begin
                res.accepted = 1'b0;
                res.action   = ACT_NONE;
            end
            res.new_state = call_st;
            res.armed     = tmr_run;
            expected_q.push_back(res);
        endfunction

        function void note_item(bit fn, logic [EVENT_W-1:0] ev);
            if (fn == FN_EVENT) begin
                take_event((ev > EV_ACTIVATE_ACK) ? EV_NONE : ev, 1'b0);
                return;
            end
            if (!tmr_run)
                return;
            if (tmr_count > 1) begin
                tmr_count = tmr_count - 1'b1;
                return;
            end
            tmr_run   = 1'b0;
            tmr_count = '0;
            take_event(EV_EXPIRY, 1'b1);
        endfunction

        function void compare(string field, logic [3:0] want, logic [3:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_call_result got);
            t_call_result want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("from_timeout", want.from_timeout, got.from_timeout);
            compare("accepted",     want.accepted,     got.accepted);
            compare("old_state",    want.old_state,    got.old_state);
            compare("new_state",    want.new_state,    got.new_state);
            compare("action_code",  want.action,       got.action);
            compare("timer_armed",  want.armed,        got.armed);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

FILE: dv/tb_top.sv
// Testbench top: drives call events and ticks into the call state machine and checks results.
`timescale 1ns / 1ps

module tb_top;

    import q931_pkg::*;
    import q931_call_sb_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;

    typedef enum {CFG_ALL_ZERO, CFG_ALL_ONE, CFG_SHORT, CFG_ALL_MAX, CFG_MIXED} t_cfg_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_func;
    logic [EVENT_W-1:0]    i_event_code;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_from_timeout;
    logic                  o_accepted;
    logic [STATE_W-1:0]    o_old_state;
    logic [STATE_W-1:0]    o_new_state;
    logic [ACTION_W-1:0]   o_action_code;
    logic                  o_timer_armed;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // calm: both sides skip their idle gaps; long_hold: receiver parks its stall high
    bit             calm;
    bit             long_hold;
    call_scoreboard sb;

    q931_call_state_machine i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_event_code   (i_event_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_from_timeout (o_from_timeout),
        .o_accepted     (o_accepted),
        .o_old_state    (o_old_state),
        .o_new_state    (o_new_state),
        .o_action_code  (o_action_code),
        .o_timer_armed  (o_timer_armed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one word and hold it until the block takes it. Entered and left at a
    // falling edge, so valid and payload only ever move away from the sampling edge.
    task automatic send_item(input bit fn, input logic [EVENT_W-1:0] ev);
        int gap;
        gap = (calm || long_hold) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func       = fn;
        i_event_code = ev;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input int idx, input logic [COUNT_W-1:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'(idx * 4);
        // upper bits are junk; only the low byte lands in the register
        pwdata  = {24'($urandom), val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_timeout(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid, wait for every expected word, then give the pipe time to
    // swallow trailing ticks, which produce no word of their own.
    task automatic settle_block();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_timeouts(input t_cfg_mode mode);
        logic [COUNT_W-1:0] val;
        for (int i = 0; i < NUM_TMO; i++) begin
            case (mode)
                CFG_ALL_ZERO: val = '0;
                CFG_ALL_ONE:  val = 8'd1;
                CFG_SHORT:    val = COUNT_W'($urandom_range(0, 3));
                CFG_ALL_MAX:  val = 8'hff;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       val = '0;
                        1:       val = 8'd1;
                        2:       val = 8'd2;
                        3:       val = 8'hff;
                        default: val = COUNT_W'($urandom);
                    endcase
                end
            endcase
            apb_write(i, val);
        end
        // Hit the two unused slots above the last timeout; both must be ignored.
        if (mode == CFG_ALL_ZERO) begin
            apb_write(NUM_TMO, 8'd3);
            apb_write(NUM_TMO + 1, 8'd7);
        end
    endtask

    // Pick the next word: a tick_pct share of ticks, a tenth arbitrary codes, and the
    // rest events the current state accepts, so calls travel deep into the table.
    // Setup ack in call init leads to overlap send, which has no way out:
    // keep it for the very end of the run.
    task automatic pick_item(input int tick_pct, output bit fn, output logic [EVENT_W-1:0] ev);
        int         roll;
        logic [8:0] step;
        roll = $urandom_range(0, 99);
        fn   = FN_EVENT;
        ev   = EVENT_W'($urandom);
        if (roll < tick_pct) begin
            fn = FN_TICK;
        end else if (roll >= tick_pct + 10) begin
            for (int k = 0; k < 16; k++) begin
                ev   = EVENT_W'($urandom_range(0, EV_ACTIVATE_ACK));
                step = sb.find_transition(sb.call_st, ev);
                if (step[8] && !(sb.call_st == ST_OUT_SETUP && ev == EV_SETUP_ACK))
                    break;
            end
        end
        if (fn == FN_EVENT && sb.call_st == ST_OUT_SETUP && ev == EV_SETUP_ACK)
            ev = EV_REL_COMPL;
    endtask

    task automatic run_phase(input int n_items, input int tick_pct, input int hold_at);
        bit                 fn;
        logic [EVENT_W-1:0] ev;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            // park the receiver and keep pushing so the block backs up
            if (n == hold_at)
                long_hold = 1'b1;
            pick_item(tick_pct, fn, ev);
            send_item(fn, ev);
        end
    endtask

    // Note accepted words and check results, both on the rising edge.
    always @(posedge i_clk) begin
        t_call_result seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_func, i_event_code);
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_from_timeout, o_accepted, o_old_state, o_new_state,
                         o_action_code, o_timer_armed};
                sb.check_result(seen);
            end
        end
    end

    // Result side: stall a random number of cycles per word, or hold for a
    // long stretch when asked, then take the next word.
    initial begin : result_sink
        int wait_cycles;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end
            wait_cycles = calm ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0) begin
                i_out_stall = 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Abort when neither channel moves a word for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        // Directed opening under the reset timeouts: tick with the timer stopped,
        // codes with no meaning, rejection while the timer runs, countdown,
        // connect request expiring back into itself, full incoming and outgoing
        // calls, disconnect request expiring to null.
        logic [4:0] opening [$];
        opening = '{
            {FN_TICK, EV_NONE},         {FN_EVENT, EV_NONE},
            {FN_EVENT, EV_EXPIRY},      {FN_EVENT, EV_REL_COMPL},
            {FN_EVENT, EV_INC_SETUP},   {FN_EVENT, EV_PROCEED_REQ},
            {FN_TICK, EV_SETUP_REQ},    {FN_EVENT, EV_SETUP_REQ},
            {FN_EVENT, EV_SETUP_RESP},  {FN_TICK, EV_NONE},
            {FN_TICK, EV_ACTIVATE_ACK}, {FN_EVENT, EV_CONNECT_ACK},
            {FN_EVENT, EV_SELECT_ACK},  {FN_EVENT, EV_ACTIVATE_ACK},
            {FN_TICK, EV_NONE},         {FN_EVENT, EV_RELEASE_REQ},
            {FN_TICK, EV_NONE},         {FN_TICK, EV_NONE},
            {FN_EVENT, EV_SETUP_REQ},   {FN_EVENT, EV_CALL_PROC},
            {FN_EVENT, EV_CONNECT},     {FN_EVENT, EV_RELEASE_REQ},
            {FN_EVENT, EV_DISCONNECT},  {FN_EVENT, EV_SETUP_REQ},
            {FN_EVENT, EV_DISCONNECT}
        };
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FN_EVENT;
        i_event_code = EV_SETUP_REQ;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening[i])
            send_item(opening[i][4], opening[i][3:0]);

        // Random phases; each new setting goes in only once the block is idle.
        run_phase(100, 30, -1);
        settle_block();
        set_timeouts(CFG_ALL_ZERO);
        run_phase(120, 30, -1);
        settle_block();
        set_timeouts(CFG_ALL_ONE);
        run_phase(120, 30, -1);
        settle_block();
        set_timeouts(CFG_SHORT);
        run_phase(150, 35, 40);
        settle_block();

        // Longest timeout: steer into a timed state and tick it all the way out.
        set_timeouts(CFG_ALL_MAX);
        if (sb.call_st == ST_NULL)
            send_item(FN_EVENT, EV_INC_SETUP);
        if (sb.call_st == ST_OUT_SETUP)
            send_item(FN_EVENT, EV_CALL_PROC);
        send_item(FN_EVENT, EV_RELEASE_REQ);
        for (int k = 0; k < 300 && sb.tmr_run; k++)
            send_item(FN_TICK, EVENT_W'($urandom));
        run_phase(100, 50, -1);
        settle_block();
        set_timeouts(CFG_MIXED);
        run_phase(80, 40, -1);

        // Walk back to null, then take the one-way trip into overlap send and
        // poke it with a few more words.
        for (int k = 0; k < 200 && sb.call_st != ST_NULL; k++) begin
            bit                 fn;
            logic [EVENT_W-1:0] ev;
            pick_item(0, fn, ev);
            send_item(fn, ev);
        end
        if (sb.call_st == ST_NULL)
            send_item(FN_EVENT, EV_SETUP_REQ);
        send_item(FN_EVENT, EV_SETUP_ACK);
        for (int k = 0; k < 6; k++)
            send_item(bit'($urandom), EVENT_W'($urandom));

        settle_block();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
